>>> rtl/mlfs_pkg.sv
// Package for the multilevel FIFO scheduler: operation and status codes.
// No dependencies.
`timescale 1ns / 1ps
package mlfs_pkg;
  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_LOOKUP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_BADPRIO  = 2'd2,
    ST_FULL     = 2'd3
  } status_e;
endpackage

>>> rtl/multilevel_fifo_scheduler.sv
// Top level of the multilevel FIFO scheduler: sequencer, entry pool, list heads.
// Depends on mlfs_pkg.
`timescale 1ns / 1ps
// Holds thread ids in one FIFO per priority level over a shared pool of CAPACITY
// entries. One item is worked at a time; in_stall_o is high while busy. Enqueue
// reads a free slot and then links it. Dequeue scans for the first busy level,
// reads its head entry, unlinks it and frees it; an empty dequeue ends after the
// scan. Remove and lookup walk the lists entry by entry through the single pool
// read port, reading and then comparing each entry. A result waits in the output
// register; the next item is taken while it waits. After reset the free list is
// rebuilt by a pass over all CAPACITY entries, during which no item is taken.
module multilevel_fifo_scheduler
  import mlfs_pkg::*;
#(
  parameter int NUM_LEVELS = 8,
  parameter int CAPACITY   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] thread_id_i,
  input  logic [3:0]  priority_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] result_id_o,
  output logic [3:0]  result_level_o,
  output logic [6:0]  occupancy_o
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(NUM_LEVELS);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_ENQ = 4'd2, S_ENQ2 = 4'd3,
    S_DSCAN = 4'd4, S_DRD = 4'd5, S_DFIN = 4'd6, S_LVL = 4'd7, S_RD = 4'd8,
    S_CMP = 4'd9, S_RLINK = 4'd10, S_RFIN = 4'd11, S_DONE = 4'd12, S_FREE = 4'd13;

  logic [15:0]   ids_mem [CAPACITY];
  logic [AW-1:0] link_mem [CAPACITY];
  logic [AW-1:0] free_mem [CAPACITY];
  logic [AW-1:0] heads_q [NUM_LEVELS];
  logic [AW-1:0] tails_q [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] nonempty_q;
  logic [LW-1:0] base_q;
  logic [CW-1:0] count_q;

  logic [3:0]    state_q;
  logic [1:0]    op_q;
  logic [15:0]   id_q;
  logic [LW:0]   lvl_q;     // logical level counter (one extra bit for end)
  logic [AW-1:0] cur_q, prev_q;
  logic          hasprev_q;
  logic [CW-1:0] init_q;
  logic [15:0]   rd_id_q;
  logic [AW-1:0] rd_link_q, rd_free_q;
  logic          out_valid_q;
  logic [1:0]    st_q;
  logic [15:0]   rid_q;
  logic [3:0]    rlvl_q;

  logic [LW-1:0] phys;
  logic [LW:0]   psum;
  assign psum = {1'b0, base_q} + lvl_q;
  assign phys = (psum >= (LW+1)'(NUM_LEVELS)) ?
                LW'(psum - (LW+1)'(NUM_LEVELS)) : psum[LW-1:0];

  assign in_stall_o = (state_q != S_IDLE);
  logic accept;
  assign accept = in_valid_i && !in_stall_o;

  // pool read address
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] free_rd;
  always_comb begin
    rd_addr = cur_q;
    free_rd = AW'(CAPACITY - 1) - AW'(count_q);
  end

  always_ff @(posedge clk_i) begin
    rd_id_q   <= ids_mem[rd_addr];
    rd_link_q <= link_mem[rd_addr];
    rd_free_q <= free_mem[free_rd];
  end

  // single write port per memory, driven by sequencer
  logic          wid_en, wlink_en, wfree_en;
  logic [AW-1:0] wid_a, wlink_a, wfree_a, wlink_d, wfree_d;
  always_ff @(posedge clk_i) begin
    if (wid_en)   ids_mem[wid_a]   <= id_q;
    if (wlink_en) link_mem[wlink_a] <= wlink_d;
    if (wfree_en) free_mem[wfree_a] <= wfree_d;
  end

  logic [AW-1:0] nfree_a;
  assign nfree_a = AW'(CAPACITY) - AW'(count_q);

  always_comb begin
    wid_en = 1'b0; wlink_en = 1'b0; wfree_en = 1'b0;
    wid_a = rd_free_q; wlink_a = tails_q[phys]; wlink_d = rd_free_q;
    wfree_a = nfree_a; wfree_d = cur_q;
    unique case (state_q)
      S_INIT: begin
        wfree_en = 1'b1; wfree_a = init_q[AW-1:0]; wfree_d = init_q[AW-1:0];
      end
      S_ENQ2: begin
        wid_en   = 1'b1;
        wlink_en = nonempty_q[phys];
      end
      S_RLINK: begin
        wlink_en = 1'b1; wlink_a = prev_q; wlink_d = rd_link_q;
      end
      S_FREE: wfree_en = (count_q != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_q      <= '0;
      nonempty_q  <= '0;
      base_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        S_INIT: begin
          init_q <= init_q + 1'b1;
          if (init_q == CW'(CAPACITY - 1)) state_q <= S_IDLE;
        end
        S_IDLE: if (accept) begin
          op_q <= operation_i; id_q <= thread_id_i;
          lvl_q <= '0; st_q <= ST_NOTFOUND; rid_q <= '0; rlvl_q <= '0;
          unique case (operation_i)
            OP_ENQ: begin
              if ({1'b0, priority_req_i} >= 5'(NUM_LEVELS)) begin
                st_q <= ST_BADPRIO; state_q <= S_DONE;
              end else if (count_q >= CW'(CAPACITY)) begin
                st_q <= ST_FULL; state_q <= S_DONE;
              end else begin
                lvl_q <= (LW+1)'(priority_req_i); state_q <= S_ENQ;
              end
            end
            OP_DEQ:  state_q <= S_DSCAN;
            default: state_q <= S_LVL;
          endcase
        end
        S_ENQ: state_q <= S_ENQ2;  // free slot read lands
        S_ENQ2: begin
          if (!nonempty_q[phys]) heads_q[phys] <= rd_free_q;
          tails_q[phys] <= rd_free_q;
          nonempty_q[phys] <= 1'b1;
          count_q <= count_q + 1'b1;
          st_q <= ST_OK;
          state_q <= S_DONE;
        end
        S_DSCAN: begin
          if (lvl_q == (LW+1)'(NUM_LEVELS)) state_q <= S_DONE;
          else if (nonempty_q[phys]) begin
            base_q <= phys; rlvl_q <= 4'(lvl_q); lvl_q <= '0;
            cur_q <= heads_q[phys]; state_q <= S_DRD;
          end else lvl_q <= lvl_q + 1'b1;
        end
        S_DRD: state_q <= S_DFIN;
        S_DFIN: begin
          rid_q <= rd_id_q; st_q <= ST_OK;
          if (cur_q == tails_q[phys]) nonempty_q[phys] <= 1'b0;
          else heads_q[phys] <= rd_link_q;
          state_q <= S_FREE;
        end
        S_LVL: begin
          if (lvl_q == (LW+1)'(NUM_LEVELS)) state_q <= S_DONE;
          else if (nonempty_q[phys]) begin
            cur_q <= heads_q[phys]; hasprev_q <= 1'b0; state_q <= S_RD;
          end else lvl_q <= lvl_q + 1'b1;
        end
        S_RD: state_q <= S_CMP;
        S_CMP: begin
          if (rd_id_q == id_q) begin
            rid_q <= id_q; rlvl_q <= 4'(lvl_q); st_q <= ST_OK;
            if (op_q == OP_REMOVE) begin
              if (!hasprev_q) begin
                if (cur_q == tails_q[phys]) nonempty_q[phys] <= 1'b0;
                else heads_q[phys] <= rd_link_q;
                state_q <= S_FREE;
              end else state_q <= S_RLINK;
            end else state_q <= S_DONE;
          end else if (cur_q == tails_q[phys]) begin
            lvl_q <= lvl_q + 1'b1; state_q <= S_LVL;
          end else begin
            prev_q <= cur_q; hasprev_q <= 1'b1; cur_q <= rd_link_q; state_q <= S_RD;
          end
        end
        S_RLINK: begin
          if (cur_q == tails_q[phys]) tails_q[phys] <= prev_q;
          state_q <= S_FREE;
        end
        S_FREE: begin
          if (count_q != '0) count_q <= count_q - 1'b1;
          state_q <= S_DONE;
        end
        S_DONE: if (!out_valid_q || !out_stall_i) begin
          out_valid_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic [6:0] occ_q;
  always_ff @(posedge clk_i)
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      status_o <= st_q; result_id_o <= rid_q; result_level_o <= rlvl_q;
      occ_q <= 7'(count_q);
    end
  assign occupancy_o = occ_q;
  assign out_valid_o = out_valid_q;
endmodule

>>> rtl/mlfs_checker.sv
// Port-level checker for the multilevel FIFO scheduler, bound to the top level.
// Depends on mlfs_pkg.
`timescale 1ns / 1ps
module mlfs_checker
  import mlfs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [15:0] result_id_o,
  input logic [6:0]  occupancy_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_id_o))
    else $error("stalled result changed");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("took a second item while busy");
  a_fail_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> result_id_o == 16'd0)
    else $error("failed op reports an id");
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> occupancy_o != 7'd0)
    else $error("pool full with no entries");
endmodule

bind multilevel_fifo_scheduler mlfs_checker u_mlfs_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .status_o, .result_id_o, .occupancy_o
);
